@@ hdl/tspc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspc_pkg: shared types and constants of the time-series point compressor
// Holds the command format passed from the classifier front end to the
// chunk emitter, the chunk selector codes and the fixed field widths.
// ----------------------------------------------------------------------------
package tspc_pkg;

  // Width of the block length field in a new-window value header.
  localparam int LEN_FIELD_BITS = 6;
  // Widest value header: '11' + 6-bit leading count + length field.
  localparam int HDR_W          = 2 + 6 + LEN_FIELD_BITS;
  localparam int HDR_LEN_W      = 4;

  // Command queue between front end and emitter.
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = 2;
  localparam int QCNT_W         = 3;

  // Which chunk of a point the emitter is on.
  typedef enum logic [1:0] {
    CH_TIME,
    CH_HEADER,
    CH_BLOCK
  } chunk_sel_t;

  // One fully classified point: every chunk ready to send.
  typedef struct packed {
    logic [31:0]          ts_bits;
    logic [5:0]           ts_len;
    logic [HDR_W-1:0]     hdr_bits;
    logic [HDR_LEN_W-1:0] hdr_len;
    logic [63:0]          blk_bits;
    logic [6:0]           blk_len;
    logic                 has_blk;
    logic                 ovf;
  } point_cmd_t;

endpackage

@@ hdl/tspc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspc_front: point classifier
// Three stages: take the point and form deltas and the value XOR, code the
// window decision, then build the timestamp, header and block chunks.
// ----------------------------------------------------------------------------
module tspc_front #(
  parameter int FIRST_TIME_BITS = 32,
  parameter int LEAD_FIELD_BITS = 5,
  parameter int MAX_LEADING     = 31
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  output logic                   full,
  input  logic                   begin_block,
  input  logic [31:0]            timestamp,
  input  logic [63:0]            value_bits,
  output logic                   cmd_valid,
  output tspc_pkg::point_cmd_t   cmd,
  input  logic                   cmd_full
);

  localparam int LEAD_FIELD_MAX = (1 << LEAD_FIELD_BITS) - 1;
  localparam int LEAD_CAP_I     = (MAX_LEADING < LEAD_FIELD_MAX) ? MAX_LEADING : LEAD_FIELD_MAX;
  localparam logic [5:0]  LEAD_CAP  = 6'(LEAD_CAP_I);
  localparam logic [5:0]  LEAD_MASK = 6'(LEAD_FIELD_MAX);
  localparam logic [31:0] TS_MASK   = 32'hFFFF_FFFF >> (32 - FIRST_TIME_BITS);
  localparam logic [5:0]  TS_RAW_LEN = 6'(FIRST_TIME_BITS);
  localparam logic [3:0]  HDR_NEW_LEN = 4'(2 + LEAD_FIELD_BITS + tspc_pkg::LEN_FIELD_BITS);

  localparam logic [31:0] TS_PFX_7  = 32'h0000_0100;  // '10'  above 7 bits
  localparam logic [31:0] TS_PFX_9  = 32'h0000_0C00;  // '110' above 9 bits
  localparam logic [31:0] TS_PFX_13 = 32'h0000_E000;  // '111' above 13 bits
  localparam logic [31:0] TS_LIM_7  = 32'h0000_0080;
  localparam logic [31:0] TS_LIM_9  = 32'h0000_0200;
  localparam logic [31:0] TS_LIM_13 = 32'h0000_2000;

  // history, updated at accept
  logic        started;
  logic [31:0] last_time;
  logic [31:0] last_delta;
  logic [63:0] last_value;
  // value window, updated in stage B
  logic [5:0]  window_leading;
  logic [5:0]  window_trailing;

  // stage A
  logic        a_valid, a_begin;
  logic [31:0] a_ts, a_delta, a_prevd;
  logic [63:0] a_x;
  // stage B
  logic        b_valid, b_begin, b_zero, b_reuse;
  logic [31:0] b_ts, b_dod;
  logic [63:0] b_x;
  logic [5:0]  b_lz, b_shift;
  logic [6:0]  b_blen;
  // stage C
  logic        c_valid;

  logic a_ready, b_ready, c_ready, accept, begin_eff;
  logic [31:0] delta_in;

  assign c_ready   = !c_valid || !cmd_full;
  assign b_ready   = !b_valid || c_ready;
  assign a_ready   = !a_valid || b_ready;
  assign full      = !a_ready;
  assign accept    = push && a_ready;
  assign begin_eff = begin_block || !started;
  assign delta_in  = timestamp - last_time;
  assign cmd_valid = c_valid;

  // stage A: take the point
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid    <= 1'b0;
      started    <= 1'b0;
      last_time  <= '0;
      last_delta <= '0;
      last_value <= '0;
    end else begin
      if (a_ready) a_valid <= accept;
      if (accept) begin
        started    <= 1'b1;
        last_time  <= timestamp;
        last_delta <= begin_eff ? 32'd0 : delta_in;
        last_value <= value_bits;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_begin <= begin_eff;
      a_ts    <= timestamp;
      a_delta <= delta_in;
      a_prevd <= last_delta;
      a_x     <= value_bits ^ (begin_eff ? 64'd0 : last_value);
    end
  end

  // stage B: zero counts and window decision
  logic [5:0] lz_raw, lz_cap, tz, wl, wt;
  logic [6:0] blk, wblk;
  logic       x_zero, reuse;

  always_comb begin
    lz_raw = 6'd63;
    tz     = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (a_x[i]) lz_raw = 6'(63 - i);
    end
    for (int i = 63; i >= 0; i--) begin
      if (a_x[i]) tz = 6'(i);
    end
    lz_cap = (lz_raw > LEAD_CAP) ? LEAD_CAP : lz_raw;
    x_zero = (a_x == 64'd0);
    wl     = a_begin ? 6'd0 : window_leading;
    wt     = a_begin ? 6'd0 : window_trailing;
    blk    = 7'd64 - 7'(lz_cap) - 7'(tz);
    wblk   = 7'd64 - 7'(wl) - 7'(wt);
    reuse  = !x_zero && (lz_cap >= wl) && (tz >= wt) &&
             (8'(wblk) < 8'(blk) + 8'(tspc_pkg::LEN_FIELD_BITS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid         <= 1'b0;
      window_leading  <= '0;
      window_trailing <= '0;
    end else begin
      if (b_ready) b_valid <= a_valid;
      if (b_ready && a_valid) begin
        if (!x_zero && !reuse) begin
          window_leading  <= lz_cap;
          window_trailing <= tz;
        end else begin
          window_leading  <= wl;
          window_trailing <= wt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      b_begin <= a_begin;
      b_ts    <= a_ts;
      b_dod   <= a_delta - a_prevd;
      b_x     <= a_x;
      b_zero  <= x_zero;
      b_reuse <= reuse;
      b_lz    <= lz_cap;
      b_shift <= reuse ? wt : tz;
      b_blen  <= reuse ? wblk : blk;
    end
  end

  // stage C: build the chunks
  logic [31:0] dd, zs, zzm1;
  tspc_pkg::point_cmd_t cmd_next;

  always_comb begin
    dd       = {b_dod[30:0], 1'b0};
    zs       = b_dod[31] ? ~dd : dd;
    zzm1     = zs - 32'd1;
    cmd_next = '0;
    if (b_begin) begin
      cmd_next.ts_bits = b_ts & TS_MASK;
      cmd_next.ts_len  = TS_RAW_LEN;
    end else if (b_dod == 32'd0) begin
      cmd_next.ts_bits = 32'd0;
      cmd_next.ts_len  = 6'd1;
    end else if (zzm1 < TS_LIM_7) begin
      cmd_next.ts_bits = zzm1 | TS_PFX_7;
      cmd_next.ts_len  = 6'd9;
    end else if (zzm1 < TS_LIM_9) begin
      cmd_next.ts_bits = zzm1 | TS_PFX_9;
      cmd_next.ts_len  = 6'd12;
    end else begin
      cmd_next.ts_bits = (zzm1 & (TS_LIM_13 - 32'd1)) | TS_PFX_13;
      cmd_next.ts_len  = 6'd16;
      cmd_next.ovf     = (zzm1 >= TS_LIM_13);
    end
    if (b_zero) begin
      cmd_next.hdr_bits = '0;
      cmd_next.hdr_len  = 4'd1;
    end else if (b_reuse) begin
      cmd_next.hdr_bits = tspc_pkg::HDR_W'(2'b10);
      cmd_next.hdr_len  = 4'd2;
    end else begin
      cmd_next.hdr_bits = (tspc_pkg::HDR_W'(2'b11) << (LEAD_FIELD_BITS + tspc_pkg::LEN_FIELD_BITS))
                        | (tspc_pkg::HDR_W'(b_lz & LEAD_MASK) << tspc_pkg::LEN_FIELD_BITS)
                        | tspc_pkg::HDR_W'(6'(b_blen - 7'd1));
      cmd_next.hdr_len  = HDR_NEW_LEN;
    end
    cmd_next.has_blk  = !b_zero;
    cmd_next.blk_bits = b_x >> b_shift;
    cmd_next.blk_len  = b_blen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_ready) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready && b_valid) cmd <= cmd_next;
  end

endmodule

@@ hdl/tspc_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspc_queue: command queue
// Small first-in first-out store that decouples classifier and emitter.
// ----------------------------------------------------------------------------
module tspc_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  tspc_pkg::point_cmd_t wr_data,
  output logic                 full,
  input  logic                 rd_en,
  output tspc_pkg::point_cmd_t rd_data,
  output logic                 empty
);

  tspc_pkg::point_cmd_t        slots [tspc_pkg::QUEUE_DEPTH];
  logic [tspc_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [tspc_pkg::QCNT_W-1:0] count;
  logic                        do_wr, do_rd;

  assign full    = (count == tspc_pkg::QCNT_W'(tspc_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

endmodule

@@ hdl/tspc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspc_back: chunk emitter
// Walks the chunks of the queue head into a registered output, one a cycle while it is popped.
// ----------------------------------------------------------------------------
module tspc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_empty,
  input  tspc_pkg::point_cmd_t q_data,
  output logic                 q_pop,
  output logic                 empty,
  input  logic                 pop,
  output logic [63:0]          code_bits,
  output logic [6:0]           code_len,
  output logic                 last_chunk,
  output logic                 dod_overflow
);

  tspc_pkg::chunk_sel_t sel;
  logic                 out_valid, load, chunk_last;
  logic [63:0]          bits_next;
  logic [6:0]           len_next;

  assign empty = !out_valid;
  assign load  = !q_empty && (!out_valid || pop);
  assign q_pop = load && chunk_last;

  always_comb begin
    unique case (sel)
      tspc_pkg::CH_TIME: begin
        bits_next  = 64'(q_data.ts_bits);
        len_next   = 7'(q_data.ts_len);
        chunk_last = 1'b0;
      end
      tspc_pkg::CH_HEADER: begin
        bits_next  = 64'(q_data.hdr_bits);
        len_next   = 7'(q_data.hdr_len);
        chunk_last = !q_data.has_blk;
      end
      tspc_pkg::CH_BLOCK: begin
        bits_next  = q_data.blk_bits;
        len_next   = q_data.blk_len;
        chunk_last = 1'b1;
      end
      default: begin
        bits_next  = '0;
        len_next   = '0;
        chunk_last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sel       <= tspc_pkg::CH_TIME;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        unique case (sel)
          tspc_pkg::CH_TIME:   sel <= tspc_pkg::CH_HEADER;
          tspc_pkg::CH_HEADER: sel <= chunk_last ? tspc_pkg::CH_TIME : tspc_pkg::CH_BLOCK;
          default:             sel <= tspc_pkg::CH_TIME;
        endcase
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_bits    <= bits_next;
      code_len     <= len_next;
      last_chunk   <= chunk_last;
      dod_overflow <= q_data.ovf;
    end
  end

endmodule

@@ hdl/timeseries_point_compressor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timeseries_point_compressor: delta-of-delta timestamp and XOR value coder
// Turns each point into two or three variable-length chunks of a stream.
// ----------------------------------------------------------------------------
//
//  channel  handshake         payload
//  -------  ----------------  ------------------------------------------------
//  input    push / full       begin_block, timestamp, value_bits
//  output   empty / pop       code_bits, code_len, last_chunk, dod_overflow
//
//  A point gives two chunks (value unchanged) or three chunks (value block
//  sent) at the output; the output register takes a single chunk per cycle
//  while the output is popped. The first chunk of a point passes the two
//  later classifier stages, the queue write and the output register after
//  the point is taken. Synchronous reset empties all stages and the queue and
//  clears the history; no clearing pass. A stalled output fills the 4-entry
//  command queue, then the classifier stages, then raises full.
//
module timeseries_point_compressor #(
  parameter int FIRST_TIME_BITS = 32,
  parameter int LEAD_FIELD_BITS = 5,
  parameter int MAX_LEADING     = 31
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        begin_block,
  input  logic [31:0] timestamp,
  input  logic [63:0] value_bits,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] code_bits,
  output logic [6:0]  code_len,
  output logic        last_chunk,
  output logic        dod_overflow
);

  // classified points, front end to queue
  tspc_pkg::point_cmd_t front_cmd;
  logic                 front_valid;
  // queue head to emitter
  tspc_pkg::point_cmd_t head_cmd;
  logic                 q_full, q_empty, q_pop;

  // Classify: deltas, zero counts, window choice, chunk packing.
  tspc_front #(
    .FIRST_TIME_BITS (FIRST_TIME_BITS),
    .LEAD_FIELD_BITS (LEAD_FIELD_BITS),
    .MAX_LEADING     (MAX_LEADING)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .begin_block (begin_block),
    .timestamp   (timestamp),
    .value_bits  (value_bits),
    .cmd_valid   (front_valid),
    .cmd         (front_cmd),
    .cmd_full    (q_full)
  );

  // Hold classified points while the emitter drains earlier ones.
  tspc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (front_valid),
    .wr_data (front_cmd),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (head_cmd),
    .empty   (q_empty)
  );

  // Emit chunks one per cycle while the output is popped; drop the head after its last chunk.
  tspc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_data       (head_cmd),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .code_bits    (code_bits),
    .code_len     (code_len),
    .last_chunk   (last_chunk),
    .dod_overflow (dod_overflow)
  );

endmodule

@@ hdl/tspc_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspc_chk: port checker of the point compressor
// Watches the output channel for sane chunks and stable stalled items.
// ----------------------------------------------------------------------------
module tspc_chk (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [63:0] code_bits,
  input logic [6:0]  code_len,
  input logic        last_chunk
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("output not empty after reset");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (code_len != 7'd0) && (code_len <= 7'd64))
    else $error("chunk length out of range");

  a_bits_fit: assert property (@(posedge clk) disable iff (rst)
    !empty && (code_len < 7'd64) |-> ((code_bits >> code_len) == 64'd0))
    else $error("chunk bits beyond its length");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(code_bits) && $stable(code_len) &&
                       $stable(last_chunk))
    else $error("stalled item changed");

endmodule

bind timeseries_point_compressor tspc_chk u_tspc_chk (
  .clk        (clk),
  .rst        (rst),
  .empty      (empty),
  .pop        (pop),
  .code_bits  (code_bits),
  .code_len   (code_len),
  .last_chunk (last_chunk)
);
